>>> hdl/value_noise_1d_sampler_core_assert.svh
// assertion macros shared by the value noise sampler checkers
`ifndef VALUE_NOISE_1D_SAMPLER_CORE_ASSERT_SVH
`define VALUE_NOISE_1D_SAMPLER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define VN1D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("value noise sampler check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define VN1D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("value noise sampler check failed");

`endif

>>> hdl/vn1d_pkg.sv
// shared constants, types and codes of the value noise sampler
package vn1d_pkg;

  localparam int TABLE_DEPTH     = 256;
  localparam int COORD_FRAC_BITS = 8;

  localparam int COORD_BITS    = 24;
  localparam int VALUE_BITS    = 16;
  localparam int ENTRY_BITS    = 8;
  localparam int CELL_BITS     = COORD_BITS - COORD_FRAC_BITS;
  localparam int IDX_BITS      = $clog2(TABLE_DEPTH);
  localparam int LEN_BITS      = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_DATA_BITS = 9;
  localparam int CFG_IDX_BITS  = 2;
  localparam int WGT_BITS      = VALUE_BITS + 1;

  // remainder pipeline retires two magnitude bits per stage
  localparam int MOD_STAGES   = (CELL_BITS + 1) / 2;
  localparam int MAG_BITS     = 2 * MOD_STAGES;
  localparam int FRONT_STAGES = MOD_STAGES + 2;
  localparam int BACK_STAGES  = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WGT_BITS-1:0] Q_ONE = WGT_BITS'(1) << VALUE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERP_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TABLE_LEN   = 2'd1;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_e;

  typedef enum logic {
    MODE_LINEAR = 1'b0,
    MODE_FADE   = 1'b1
  } interp_e;

  typedef struct packed {
    interp_e             mode;
    logic [LEN_BITS-1:0] len;
  } cfg_t;

  // one classified request between front and back
  typedef struct packed {
    req_e                  kind;
    logic [IDX_BITS-1:0]   addr_a;
    logic [IDX_BITS-1:0]   addr_b;
    logic [VALUE_BITS-1:0] data;
  } q_item_t;

  typedef struct packed {
    logic    push;
    q_item_t item;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hdl/value_noise_1d_sampler_core.sv
// top level of the one-dimensional value noise sampler
// A load request writes one Q0.16 value into the value table; a sample request
// floors its signed Q15.8 coordinate, wraps the cell and its right neighbor
// into the first table_len entries (a true floor modulo, so negative
// coordinates wrap) and blends the two values linearly or with the quintic
// fade. One request is accepted every cycle while in_stall_o is low, loads and
// samples alike; a sample result passes 10 front stages, where the floor
// modulo is a restoring remainder that retires two bits per stage, then the
// queue and 8 back stages that hold the table read, the four chained Q0.16
// multiplies of the fade and the blend multiply. A four entry queue between
// the halves lets either side stall alone. The table is not cleared after
// reset; reading an entry that was never loaded returns an undefined value.
// Configuration writes belong in idle periods.
module value_noise_1d_sampler_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [vn1d_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [vn1d_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  // request channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   req_type_i,
  input  logic [vn1d_pkg::ENTRY_BITS-1:0]        entry_index_i,
  input  logic [vn1d_pkg::VALUE_BITS-1:0]        entry_value_i,
  input  logic signed [vn1d_pkg::COORD_BITS-1:0] coord_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [vn1d_pkg::VALUE_BITS-1:0]        noise_value_o
);

  // table length as held after reset, already saturated to the table
  localparam int LEN_RESET = (vn1d_pkg::TABLE_DEPTH < 256) ? vn1d_pkg::TABLE_DEPTH : 256;

  vn1d_pkg::cfg_t      cfg_q, cfg_d;
  vn1d_pkg::q_push_t   q_push;
  vn1d_pkg::q_item_t   q_item;
  vn1d_pkg::q_status_t q_status;
  logic                q_pop;

  // table length of zero acts as one, anything past the table saturates
  function automatic logic [vn1d_pkg::LEN_BITS-1:0] eff_len(
    input logic [vn1d_pkg::CFG_DATA_BITS-1:0] v
  );
    logic [vn1d_pkg::LEN_BITS-1:0] n;
    if (v == '0) begin
      n = vn1d_pkg::LEN_BITS'(1);
    end else if (int'(v) > vn1d_pkg::TABLE_DEPTH) begin
      n = vn1d_pkg::LEN_BITS'(vn1d_pkg::TABLE_DEPTH);
    end else begin
      n = vn1d_pkg::LEN_BITS'(v);
    end
    return n;
  endfunction

  // register decode; unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        vn1d_pkg::CFG_INTERP_MODE: begin
          cfg_d.mode = vn1d_pkg::interp_e'(cfg_data_i[0]);
        end
        vn1d_pkg::CFG_TABLE_LEN: begin
          cfg_d.len = eff_len(cfg_data_i);
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= vn1d_pkg::MODE_FADE;
      cfg_q.len  <= vn1d_pkg::LEN_BITS'(LEN_RESET);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify and wrap the index
  vn1d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .entry_index_i(entry_index_i),
    .entry_value_i(entry_value_i),
    .coord_i      (coord_i),
    .q_status_i   (q_status),
    .q_push_o     (q_push)
  );

  // decoupling queue, keeps request order so loads and samples never pass
  vn1d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .status_o(q_status)
  );

  // table access, weight and blend
  vn1d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_status_i   (q_status),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .noise_value_o(noise_value_o)
  );

endmodule

>>> hdl/vn1d_ram.sv
// generic ram, one write port, two registered read ports
module vn1d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> hdl/vn1d_queue.sv
// short request queue between the front and back halves
module vn1d_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vn1d_pkg::q_push_t   push_i,
  input  logic                pop_i,
  output vn1d_pkg::q_item_t   item_o,
  output vn1d_pkg::q_status_t status_o
);

  vn1d_pkg::q_item_t                  mem_q [vn1d_pkg::QUEUE_DEPTH];
  logic [vn1d_pkg::QPTR_BITS-1:0]     wptr_q, wptr_d;
  logic [vn1d_pkg::QPTR_BITS-1:0]     rptr_q, rptr_d;
  logic [vn1d_pkg::QCNT_BITS-1:0]     cnt_q, cnt_d;

  localparam logic [vn1d_pkg::QPTR_BITS-1:0] PTR_LAST =
    vn1d_pkg::QPTR_BITS'(vn1d_pkg::QUEUE_DEPTH - 1);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i.push) begin
      wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
    end
    if (push_i.push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i.push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wptr_q] <= push_i.item;
    end
  end

  assign item_o         = mem_q[rptr_q];
  assign status_o.full  = (cnt_q == vn1d_pkg::QCNT_BITS'(vn1d_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

>>> hdl/vn1d_front.sv
// front half: takes requests, floors and wraps the cell index
module vn1d_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  vn1d_pkg::cfg_t                        cfg_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  req_type_i,
  input  logic [vn1d_pkg::ENTRY_BITS-1:0]       entry_index_i,
  input  logic [vn1d_pkg::VALUE_BITS-1:0]       entry_value_i,
  input  logic signed [vn1d_pkg::COORD_BITS-1:0] coord_i,
  input  vn1d_pkg::q_status_t                   q_status_i,
  output vn1d_pkg::q_push_t                     q_push_o
);

  typedef struct packed {
    vn1d_pkg::req_e                  kind;
    logic [vn1d_pkg::IDX_BITS-1:0]   idx;
    logic [vn1d_pkg::VALUE_BITS-1:0] data;
    logic                            neg;
    logic [vn1d_pkg::MAG_BITS-1:0]   mag;
    logic [vn1d_pkg::IDX_BITS-1:0]   rem;
  } fst_t;

  localparam int MS = vn1d_pkg::MOD_STAGES;

  // one restoring remainder step
  function automatic logic [vn1d_pkg::IDX_BITS-1:0] rem_step(
    input logic [vn1d_pkg::IDX_BITS-1:0] rem,
    input logic                          b,
    input logic [vn1d_pkg::LEN_BITS-1:0] len
  );
    logic [vn1d_pkg::LEN_BITS:0] r;
    r = (vn1d_pkg::LEN_BITS + 1)'({rem, b});
    if (r >= {1'b0, len}) begin
      r = r - {1'b0, len};
    end
    return vn1d_pkg::IDX_BITS'(r);
  endfunction

  fst_t              st_q [MS+1];
  fst_t              st_d [MS+1];
  logic [MS:0]       vld_q;
  vn1d_pkg::q_item_t out_q, out_d;
  logic              out_vld_q;
  logic              f_en;
  logic              accept;
  logic              load_ok;
  vn1d_pkg::req_e    kind;

  logic [vn1d_pkg::CELL_BITS-1:0]   cell_no;
  logic [vn1d_pkg::CELL_BITS-1:0]   mag_c;
  logic [vn1d_pkg::LEN_BITS-1:0]    nxt;
  logic [vn1d_pkg::IDX_BITS-1:0]    left;
  logic [vn1d_pkg::COORD_FRAC_BITS-1:0] frac;

  assign f_en       = !(out_vld_q && q_status_i.full);
  assign in_stall_o = !f_en;
  assign kind       = vn1d_pkg::req_e'(req_type_i);
  assign load_ok    = (int'(entry_index_i) < vn1d_pkg::TABLE_DEPTH);
  // out of range loads are dropped here
  assign accept     = in_valid_i && f_en && (kind == vn1d_pkg::REQ_SAMPLE || load_ok);

  assign cell_no = coord_i[vn1d_pkg::COORD_BITS-1:vn1d_pkg::COORD_FRAC_BITS];
  assign frac    = coord_i[vn1d_pkg::COORD_FRAC_BITS-1:0];
  assign mag_c   = cell_no[vn1d_pkg::CELL_BITS-1] ? (~cell_no + 1'b1) : cell_no;

  always_comb begin
    st_d[0].kind = kind;
    st_d[0].idx  = vn1d_pkg::IDX_BITS'(entry_index_i);
    st_d[0].data = (kind == vn1d_pkg::REQ_LOAD) ? entry_value_i :
                   (vn1d_pkg::VALUE_BITS'(frac)
                    << (vn1d_pkg::VALUE_BITS - vn1d_pkg::COORD_FRAC_BITS));
    st_d[0].neg  = cell_no[vn1d_pkg::CELL_BITS-1];
    st_d[0].mag  = vn1d_pkg::MAG_BITS'(mag_c);
    st_d[0].rem  = '0;
    for (int s = 1; s <= MS; s++) begin
      st_d[s]     = st_q[s-1];
      st_d[s].rem = rem_step(rem_step(st_q[s-1].rem, st_q[s-1].mag[vn1d_pkg::MAG_BITS-1],
                                      cfg_i.len),
                             st_q[s-1].mag[vn1d_pkg::MAG_BITS-2], cfg_i.len);
      st_d[s].mag = st_q[s-1].mag << 2;
    end
  end

  // floor correction and right neighbor
  always_comb begin
    if (st_q[MS].neg && st_q[MS].rem != '0) begin
      left = vn1d_pkg::IDX_BITS'(cfg_i.len - vn1d_pkg::LEN_BITS'(st_q[MS].rem));
    end else begin
      left = st_q[MS].rem;
    end
    nxt         = vn1d_pkg::LEN_BITS'(left) + 1'b1;
    out_d.kind  = st_q[MS].kind;
    out_d.data  = st_q[MS].data;
    if (st_q[MS].kind == vn1d_pkg::REQ_LOAD) begin
      out_d.addr_a = st_q[MS].idx;
      out_d.addr_b = st_q[MS].idx;
    end else begin
      out_d.addr_a = left;
      out_d.addr_b = (nxt == cfg_i.len) ? '0 : vn1d_pkg::IDX_BITS'(nxt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (f_en) begin
      vld_q     <= {vld_q[MS-1:0], accept};
      out_vld_q <= vld_q[MS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_en) begin
      for (int s = 0; s <= MS; s++) begin
        st_q[s] <= st_d[s];
      end
      out_q <= out_d;
    end
  end

  assign q_push_o.push = out_vld_q && !q_status_i.full;
  assign q_push_o.item = out_q;

endmodule

>>> hdl/vn1d_back.sv
// back half: table access, fade weight and blend
module vn1d_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vn1d_pkg::cfg_t                  cfg_i,
  input  vn1d_pkg::q_status_t             q_status_i,
  input  vn1d_pkg::q_item_t               q_item_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [vn1d_pkg::VALUE_BITS-1:0] noise_value_o
);

  localparam int VB = vn1d_pkg::VALUE_BITS;
  localparam int WB = vn1d_pkg::WGT_BITS;
  localparam int PB = VB + WB;

  function automatic logic [VB-1:0] mul_q16(input logic [VB-1:0] a, input logic [VB-1:0] b);
    logic [2*VB-1:0] p;
    p = (2*VB)'(a) * (2*VB)'(b);
    return p[2*VB-1:VB];
  endfunction

  logic [vn1d_pkg::BACK_STAGES-1:0] vld_q;
  logic                             b_en;
  logic                             is_load;
  logic [VB-1:0] rd_a, rd_b;

  logic [VB-1:0] t1_q;
  logic [VB-1:0] t2_q, sq2_q, wl2_q, wr2_q;
  logic [VB-1:0] t3_q, cu3_q, wl3_q, wr3_q;
  logic [VB-1:0] t4_q, cu4_q, qu4_q, wl4_q, wr4_q;
  logic [VB-1:0] t5_q, cu5_q, qu5_q, qn5_q, wl5_q, wr5_q;
  logic [WB-1:0] k6_q, k6_d;
  logic [VB-1:0] wl6_q, wr6_q;
  logic [PB-1:0] pr7_q, pl7_q;
  logic [VB-1:0] out_q;
  logic [PB:0]   sum;
  logic [21:0]   fade_pos, fade_neg, fade_diff;

  assign b_en    = !(vld_q[vn1d_pkg::BACK_STAGES-1] && out_stall_i);
  assign q_pop_o = b_en && !q_status_i.empty;
  assign is_load = (q_item_i.kind == vn1d_pkg::REQ_LOAD);

  vn1d_ram #(
    .WIDTH(VB),
    .DEPTH(vn1d_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (q_pop_o && is_load),
    .waddr_i  (q_item_i.addr_a),
    .wdata_i  (q_item_i.data),
    .re_i     (b_en),
    .raddr_a_i(q_item_i.addr_a),
    .raddr_b_i(q_item_i.addr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  // fade mode: 6t^5 - 15t^4 + 10t^3 clamped into [0, 1]; linear mode: t itself
  always_comb begin
    fade_pos  = 22'(qn5_q) * 22'd6 + 22'(cu5_q) * 22'd10;
    fade_neg  = 22'(qu5_q) * 22'd15;
    fade_diff = fade_pos - fade_neg;
    if (cfg_i.mode == vn1d_pkg::MODE_LINEAR) begin
      k6_d = WB'(t5_q);
    end else if (fade_pos < fade_neg) begin
      k6_d = '0;
    end else if (fade_diff > 22'(vn1d_pkg::Q_ONE)) begin
      k6_d = vn1d_pkg::Q_ONE;
    end else begin
      k6_d = fade_diff[WB-1:0];
    end
  end

  assign sum = (PB+1)'(pr7_q) + (PB+1)'(pl7_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (b_en) begin
      vld_q <= {vld_q[vn1d_pkg::BACK_STAGES-2:0], q_pop_o && !is_load};
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_en) begin
      t1_q  <= q_item_i.data;
      t2_q  <= t1_q;
      sq2_q <= mul_q16(t1_q, t1_q);
      wl2_q <= rd_a;
      wr2_q <= rd_b;
      t3_q  <= t2_q;
      cu3_q <= mul_q16(sq2_q, t2_q);
      wl3_q <= wl2_q;
      wr3_q <= wr2_q;
      t4_q  <= t3_q;
      cu4_q <= cu3_q;
      qu4_q <= mul_q16(cu3_q, t3_q);
      wl4_q <= wl3_q;
      wr4_q <= wr3_q;
      t5_q  <= t4_q;
      cu5_q <= cu4_q;
      qu5_q <= qu4_q;
      qn5_q <= mul_q16(qu4_q, t4_q);
      wl5_q <= wl4_q;
      wr5_q <= wr4_q;
      k6_q  <= k6_d;
      wl6_q <= wl5_q;
      wr6_q <= wr5_q;
      pr7_q <= PB'(wr6_q) * PB'(k6_q);
      pl7_q <= PB'(wl6_q) * PB'(vn1d_pkg::Q_ONE - k6_q);
      out_q <= sum[2*VB-1:VB];
    end
  end

  assign out_valid_o   = vld_q[vn1d_pkg::BACK_STAGES-1];
  assign noise_value_o = out_q;

endmodule

>>> hdl/vn1d_checker.sv
// port level checks of the value noise sampler and their binding
`include "value_noise_1d_sampler_core_assert.svh"

module vn1d_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            req_type_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [vn1d_pkg::VALUE_BITS-1:0] noise_value_o
);

  // most samples that can be in flight at once
  localparam int PEND_MAX =
    vn1d_pkg::FRONT_STAGES + vn1d_pkg::QUEUE_DEPTH + vn1d_pkg::BACK_STAGES;
  localparam int PEND_W = $clog2(PEND_MAX + 2);

  logic [PEND_W-1:0] pend_q, pend_d;
  logic              sample_in;
  logic              result_out;

  assign sample_in  = in_valid_i && !in_stall_o &&
                      (vn1d_pkg::req_e'(req_type_i) == vn1d_pkg::REQ_SAMPLE);
  assign result_out = out_valid_o && !out_stall_i;

  always_comb begin
    pend_d = pend_q;
    if (sample_in && !result_out) begin
      pend_d = pend_q + 1'b1;
    end else if (result_out && !sample_in) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `VN1D_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o && $stable(noise_value_o))
  `VN1D_ASSERT_NOW(a_no_spurious_result, out_valid_o, pend_q != '0)
  `VN1D_ASSERT_NOW(a_inflight_bounded, 1'b1, pend_q <= PEND_W'(PEND_MAX))

endmodule

bind value_noise_1d_sampler_core vn1d_checker u_checker (.*);
